[rtl/i2c_scl_divider_search_top_assert.svh]
// Assertion macros for the SCL divider search block.
`ifndef I2C_SCL_DIVIDER_SEARCH_TOP_ASSERT_SVH
`define I2C_SCL_DIVIDER_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define I2CSCL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define I2CSCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/i2cscl_pkg.sv]
package i2cscl_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = 6;
  localparam int DIV_W         = 12;
  localparam int CLK_W         = 32;
  localparam int REQ_W         = 23;
  localparam int ERR_W         = 16;
  localparam int CODE_W        = 2;

  localparam logic [ERR_W-1:0]  ERR_LIMIT       = 16'hFFFF;
  localparam logic [CLK_W-1:0]  BUS_CLOCK_RESET = 32'd60000000;
  localparam logic [CODE_W-1:0] CODE_X1         = 2'd0;
  localparam logic [CODE_W-1:0] CODE_X4         = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CLK_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              status;
    logic [IDX_W-1:0]  divider_index;
    logic [CODE_W-1:0] multiplier_code;
    logic [REQ_W-1:0]  achieved_rate;
    logic [ERR_W-1:0]  rate_error;
  } res_t;

  function automatic logic [DIV_W-1:0] scl_divisor(input logic [IDX_W-1:0] idx);
    logic [DIV_W-1:0] d;
    unique case (idx)
      6'd0:  d = 12'd20;   6'd1:  d = 12'd22;   6'd2:  d = 12'd24;   6'd3:  d = 12'd26;
      6'd4:  d = 12'd28;   6'd5:  d = 12'd30;   6'd6:  d = 12'd34;   6'd7:  d = 12'd40;
      6'd8:  d = 12'd28;   6'd9:  d = 12'd32;   6'd10: d = 12'd36;   6'd11: d = 12'd40;
      6'd12: d = 12'd44;   6'd13: d = 12'd48;   6'd14: d = 12'd56;   6'd15: d = 12'd68;
      6'd16: d = 12'd48;   6'd17: d = 12'd56;   6'd18: d = 12'd64;   6'd19: d = 12'd72;
      6'd20: d = 12'd80;   6'd21: d = 12'd88;   6'd22: d = 12'd104;  6'd23: d = 12'd128;
      6'd24: d = 12'd80;   6'd25: d = 12'd96;   6'd26: d = 12'd112;  6'd27: d = 12'd128;
      6'd28: d = 12'd144;  6'd29: d = 12'd160;  6'd30: d = 12'd192;  6'd31: d = 12'd240;
      6'd32: d = 12'd160;  6'd33: d = 12'd192;  6'd34: d = 12'd224;  6'd35: d = 12'd256;
      6'd36: d = 12'd288;  6'd37: d = 12'd320;  6'd38: d = 12'd384;  6'd39: d = 12'd480;
      6'd40: d = 12'd320;  6'd41: d = 12'd384;  6'd42: d = 12'd448;  6'd43: d = 12'd512;
      6'd44: d = 12'd576;  6'd45: d = 12'd640;  6'd46: d = 12'd768;  6'd47: d = 12'd960;
      6'd48: d = 12'd640;  6'd49: d = 12'd768;  6'd50: d = 12'd896;  6'd51: d = 12'd1024;
      6'd52: d = 12'd1152; 6'd53: d = 12'd1280; 6'd54: d = 12'd1536; 6'd55: d = 12'd1920;
      6'd56: d = 12'd1280; 6'd57: d = 12'd1536; 6'd58: d = 12'd1792; 6'd59: d = 12'd2048;
      6'd60: d = 12'd2304; 6'd61: d = 12'd2560; 6'd62: d = 12'd3072; 6'd63: d = 12'd3840;
      default: d = 12'd20;
    endcase
    return d;
  endfunction

endpackage

[rtl/i2cscl_div.sv]
module i2cscl_div
  import i2cscl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  input  logic [CLK_W-1:0] dividend,
  output div_rsp_t         rsp
);

  logic [CLK_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [4:0]       cnt;
  logic             busy;
  logic             done;
  logic [DIV_W-1:0] divisor;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             take;

  assign trial = {rem, quo[CLK_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign take  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[CLK_W-2:0], take};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[rtl/i2cscl_seq.sv]
module i2cscl_seq
  import i2cscl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [REQ_W-1:0] requested_rate,
  input  logic             out_full,
  output div_req_t         div_req,
  input  div_rsp_t         div_rsp,
  output logic             res_valid,
  output res_t             res
);

`include "i2c_scl_divider_search_top_assert.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIVW  = 3'd2;
  localparam logic [2:0] S_HALVE = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state;
  logic [IDX_W-1:0]  idx;
  logic [REQ_W-1:0]  req;
  logic [CLK_W-1:0]  rate;
  logic [CODE_W-1:0] code;
  logic [ERR_W-1:0]  best_err;
  logic [IDX_W-1:0]  best_idx;
  logic [REQ_W-1:0]  best_rate;
  logic [CODE_W-1:0] best_code;
  logic              found;

  logic              above;
  logic              last;
  logic [REQ_W-1:0]  err;
  logic              better;

  assign above  = (rate > {{(CLK_W-REQ_W){1'b0}}, req});
  assign last   = (idx == IDX_W'(TABLE_ENTRIES - 1));
  assign err    = req - rate[REQ_W-1:0];
  assign better = (err < {{(REQ_W-ERR_W){1'b0}}, best_err});

  assign in_ready        = (state == S_IDLE) && !out_full;
  assign div_req.start   = (state == S_START);
  assign div_req.divisor = scl_divisor(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) state <= S_START;
        end
        S_START: state <= S_DIVW;
        S_DIVW: begin
          if (div_rsp.done) state <= S_HALVE;
        end
        S_HALVE: begin
          if (!above) state <= S_CMP;
          else if (code == CODE_X4) state <= last ? S_DONE : S_START;
        end
        S_CMP: state <= last ? S_DONE : S_START;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          req       <= requested_rate;
          idx       <= '0;
          best_err  <= ERR_LIMIT;
          best_idx  <= '0;
          best_rate <= '0;
          best_code <= CODE_X1;
          found     <= 1'b0;
        end
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          rate <= div_rsp.quotient;
          code <= CODE_X1;
        end
      end
      S_HALVE: begin
        if (above) begin
          if (code == CODE_X4) begin
            if (!last) idx <= idx + IDX_W'(1);
          end else begin
            rate <= rate >> 1;
            code <= code + CODE_W'(1);
          end
        end
      end
      S_CMP: begin
        if (better) begin
          best_err  <= err[ERR_W-1:0];
          best_idx  <= idx;
          best_rate <= rate[REQ_W-1:0];
          best_code <= code;
          found     <= 1'b1;
        end
        if (!last) idx <= idx + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign res_valid           = (state == S_DONE);
  assign res.status          = !found;
  assign res.divider_index   = best_idx;
  assign res.multiplier_code = best_code;
  assign res.achieved_rate   = best_rate;
  assign res.rate_error      = found ? best_err : '0;

  `I2CSCL_ASSERT_NOW(a_cmp_not_above, state == S_CMP, rate <= {{(CLK_W-REQ_W){1'b0}}, req}, "compare with rate above request")
  `I2CSCL_ASSERT_NEXT(a_skip_entry, state == S_HALVE && above && code == CODE_X4, state == S_START || state == S_DONE, "entry above request not skipped")
  `I2CSCL_ASSERT_NOW(a_result_err, res_valid && found, best_err == ERR_W'(req - best_rate), "result error does not match rate")
  `I2CSCL_ASSERT_NOW(a_no_accept_busy, state != S_IDLE, !in_ready, "word accepted during search")

endmodule

[rtl/i2c_scl_divider_search_top.sv]
// Picks the I2C SCL divider table entry and prescale (x1, x2, x4) whose rate is
// closest to, but not above, the requested rate, for the bus clock held in the
// configuration register (reset 60 MHz). For each of the 64 table entries the
// bit-serial 32-bit divider (one quotient bit a cycle) divides the bus clock
// by its divisor; the rate is halved while above the request, up to x4 (else
// the entry is skipped), then compared with the best so far. A new request is
// taken once the previous result has been read out.
module i2c_scl_divider_search_top
  import i2cscl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CLK_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  requested_rate,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic [IDX_W-1:0]  divider_index,
  output logic [CODE_W-1:0] multiplier_code,
  output logic [REQ_W-1:0]  achieved_rate,
  output logic [ERR_W-1:0]  rate_error
);

  logic [CLK_W-1:0] bus_clock_hz;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic             res_valid;
  res_t             res;
  res_t             out_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_clock_hz <= BUS_CLOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bus_clock_hz <= cfg_data;
    end
  end

  i2cscl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (bus_clock_hz),
    .rsp      (div_rsp)
  );

  i2cscl_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .requested_rate (requested_rate),
    .out_full       (out_valid),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .res_valid      (res_valid),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_word <= res;
  end

  assign status          = out_word.status;
  assign divider_index   = out_word.divider_index;
  assign multiplier_code = out_word.multiplier_code;
  assign achieved_rate   = out_word.achieved_rate;
  assign rate_error      = out_word.rate_error;

endmodule

[sim/testbench.sv]
package scl_search_check_pkg;
  import i2cscl_pkg::*;

  localparam logic [CODE_W-1:0] CODE_X2 = 2'd1;

  localparam int unsigned SCL_DIVISORS [TABLE_ENTRIES] = '{
      20,   22,   24,   26,   28,   30,   34,   40,
      28,   32,   36,   40,   44,   48,   56,   68,
      48,   56,   64,   72,   80,   88,  104,  128,
      80,   96,  112,  128,  144,  160,  192,  240,
     160,  192,  224,  256,  288,  320,  384,  480,
     320,  384,  448,  512,  576,  640,  768,  960,
     640,  768,  896, 1024, 1152, 1280, 1536, 1920,
    1280, 1536, 1792, 2048, 2304, 2560, 3072, 3840
  };

  class scl_choice_tracker;
    logic [CLK_W-1:0] bus_clock;
    res_t pending_choices[$];
    int mismatches;

    function new();
      bus_clock = BUS_CLOCK_RESET;
      mismatches = 0;
    endfunction

    function res_t best_divider(input logic [REQ_W-1:0] req);
      res_t best;
      logic [31:0] rate;
      logic [31:0] err;
      logic [31:0] best_err;
      logic [CODE_W-1:0] code;
      int i;
      best = '0;
      best.status = 1'b1;
      best_err = 32'(ERR_LIMIT);
      for (i = 0; i < TABLE_ENTRIES; i++) begin
        rate = bus_clock / SCL_DIVISORS[i];
        code = CODE_X1;
        if (rate > 32'(req)) begin
          rate = rate >> 1;
          code = CODE_X2;
        end
        if (rate > 32'(req)) begin
          rate = rate >> 1;
          code = CODE_X4;
        end
        if (rate <= 32'(req)) begin
          err = 32'(req) - rate;
          if (err < best_err) begin
            best_err = err;
            best.status = 1'b0;
            best.divider_index = i[IDX_W-1:0];
            best.multiplier_code = code;
            best.achieved_rate = rate[REQ_W-1:0];
            best.rate_error = err[ERR_W-1:0];
          end
        end
      end
      return best;
    endfunction

    function void note_request(input logic [REQ_W-1:0] req);
      pending_choices.push_back(best_divider(req));
    endfunction

    task report(input string what, input longint unsigned got, input longint unsigned want);
      $display("testbench: %s mismatch, got %0d, expected %0d", what, got, want);
      mismatches++;
    endtask

    task check_result(input res_t got);
      res_t want;
      if (pending_choices.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        want = pending_choices.pop_front();
        if (got.status !== want.status)
          report("status", got.status, want.status);
        if (got.divider_index !== want.divider_index)
          report("divider_index", got.divider_index, want.divider_index);
        if (got.multiplier_code !== want.multiplier_code)
          report("multiplier_code", got.multiplier_code, want.multiplier_code);
        if (got.achieved_rate !== want.achieved_rate)
          report("achieved_rate", got.achieved_rate, want.achieved_rate);
        if (got.rate_error !== want.rate_error)
          report("rate_error", got.rate_error, want.rate_error);
      end
    endtask
  endclass

endpackage

module testbench;
  import i2cscl_pkg::*;
  import scl_search_check_pkg::*;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CLK_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [REQ_W-1:0]  requested_rate;
  logic              out_valid;
  logic              out_ready;
  logic              status;
  logic [IDX_W-1:0]  divider_index;
  logic [CODE_W-1:0] multiplier_code;
  logic [REQ_W-1:0]  achieved_rate;
  logic [ERR_W-1:0]  rate_error;

  scl_choice_tracker tracker = new();
  logic [REQ_W-1:0] request_queue[$];

  i2c_scl_divider_search_top dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .requested_rate  (requested_rate),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .divider_index   (divider_index),
    .multiplier_code (multiplier_code),
    .achieved_rate   (achieved_rate),
    .rate_error      (rate_error)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("testbench: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        tracker.note_request(requested_rate);
      if (out_valid && out_ready)
        tracker.check_result({status, divider_index, multiplier_code, achieved_rate,
                              rate_error});
    end
  end

  initial begin
    int len;
    logic level;
    out_ready <= 1'b0;
    forever begin
      level = 1'($urandom_range(0, 1));
      len = level ? $urandom_range(1, 400) : $urandom_range(1, 40);
      out_ready <= level;
      repeat (len) @(posedge clk);
    end
  end

  function automatic logic [REQ_W-1:0] pick_request(input logic [CLK_W-1:0] bus);
    logic [31:0] base;
    logic [31:0] r;
    base = (bus / SCL_DIVISORS[$urandom_range(0, TABLE_ENTRIES - 1)]) >> $urandom_range(0, 2);
    case ($urandom_range(0, 9))
      0, 1, 2: r = base + $urandom_range(0, 3);
      3:       r = base - $urandom_range(0, 3);
      4:       r = base + 32'd65532 + $urandom_range(0, 5);
      5:       r = $urandom_range(1, 5000000);
      6:       r = $urandom;
      7:       r = $urandom_range(0, 4000);
      default: r = (32'd1 << $urandom_range(0, 22)) | ($urandom & ((32'd1 << $urandom_range(0, 22)) - 1));
    endcase
    return r[REQ_W-1:0];
  endfunction

  task send_request(input logic [REQ_W-1:0] req);
    in_valid <= 1'b1;
    requested_rate <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_choices.size() != 0) @(posedge clk);
  endtask

  task feed_queue();
    int burst;
    int gap;
    while (request_queue.size() > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && request_queue.size() > 0) begin
        send_request(request_queue.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 2600) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if ($urandom_range(0, 15) == 0)
        drain_results();
    end
  endtask

  task write_bus_clock(input logic [CLK_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.bus_clock = value;
  endtask

  task run_phase(input logic [CLK_W-1:0] bus, input int count);
    drain_results();
    write_bus_clock(bus);
    repeat (count) request_queue.push_back(pick_request(bus));
    feed_queue();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    requested_rate <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset bus clock: limits, halving edges, ties, error limit
    request_queue = '{23'd0, 23'd1, 23'd3905, 23'd3906, 23'd3907, 23'd15625, 23'd100000,
                      23'd375000, 23'd400000, 23'd1000000, 23'd1500000, 23'd2142857,
                      23'd3000000, 23'd3065534, 23'd3065535, 23'd5000000, 23'h7FFFFF,
                      23'h555555, 23'h2AAAAA};
    feed_queue();

    // zero bus clock: every entry gives rate zero
    drain_results();
    write_bus_clock(32'd0);
    request_queue = '{23'd0, 23'd1, 23'd65534, 23'd65535, 23'h7FFFFF};
    repeat (8) request_queue.push_back(pick_request(32'd0));
    feed_queue();

    run_phase(32'd1, 12);
    run_phase(32'hFFFFFFFF, 40);
    run_phase(32'd48000000, 45);
    run_phase(32'd100000000, 45);
    run_phase($urandom, 40);
    run_phase(32'd8000000, 40);
    run_phase(32'd60000000, 40);

    drain_results();
    repeat (2500) @(posedge clk);
    if (tracker.pending_choices.size() != 0)
      tracker.report("leftover expectation", tracker.pending_choices.size(), 0);
    if (tracker.mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/i2cscl_pkg.sv
rtl/i2cscl_div.sv
rtl/i2cscl_seq.sv
rtl/i2c_scl_divider_search_top.sv
sim/testbench.sv
